// ----- src/mttb_pkg.sv -----
// ----------------------------------------------------------------------------
// mttb_pkg
// Shared widths, codes, pipeline depths and CORDIC angle tables for the
// tile-to-bounding-box pipeline.
// ----------------------------------------------------------------------------
package mttb_pkg;

	localparam int MAX_ZOOM_DEF  = 24;
	localparam int FRAC_BITS_DEF = 16;

	localparam int TILE_W  = 24;
	localparam int ZOOM_W  = 5;
	localparam int PROJ_W  = 2;
	localparam int HW_W    = 26;
	localparam int IDX_W   = 1;
	localparam int COORD_W = 42;
	localparam int EDGE_W  = TILE_W + 1;
	localparam int NUM_W   = 33;
	localparam int MUL_W   = HW_W + 1;

	localparam logic [PROJ_W-1:0] PROJ_GEO     = 2'd0;
	localparam logic [PROJ_W-1:0] PROJ_MERC    = 2'd1;
	localparam logic [PROJ_W-1:0] PROJ_UNKNOWN = 2'd2;
	localparam logic [PROJ_W-1:0] PROJ_SPARE   = 2'd3;

	localparam logic [IDX_W-1:0] REG_PROJECTION = 1'b0;
	localparam logic [IDX_W-1:0] REG_HALF_WORLD = 1'b1;

	localparam logic [HW_W-1:0] HALF_WORLD_RST = 26'd20037508;

	localparam logic signed [COORD_W-1:0] OUT_HI = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] OUT_LO = {1'b1, {(COORD_W-1){1'b0}}};

	localparam longint unsigned PI_Q30       = 64'h00000000C90FDAA2;
	localparam longint unsigned QUARTER_PI60 = 64'h0C90FDAA22168C23;

	localparam int HYP_STEPS = 32;
	localparam int CIR_STEPS = 31;
	localparam int LIN_DEPTH = 3;
	// front (2) + hyperbolic + products (3) + circular + degree scaling (2)
	localparam int LAT_DEPTH = 2 + HYP_STEPS + 3 + CIR_STEPS + 2;

	// shift of hyperbolic step k; shifts 4 and 13 run twice
	function automatic int hyp_shift(input int k);
		if (k <= 3)
			return k + 1;
		else if (k <= 13)
			return k;
		else
			return k - 1;
	endfunction

	// atanh(2^-i), Q30
	function automatic longint hyp_q30(input int i);
		longint unsigned th;
		longint unsigned term;
		int d;
		th = 64'd0;
		for (int k = 0; k < 31; k++) begin
			d = 2 * k + 1;
			if (i * d <= 60) begin
				term = (64'd1 << (60 - i * d)) / 64'(d);
				th = th + term;
			end
		end
		return longint'((th + 64'd536870912) >> 30);
	endfunction

	// atan(2^-i)/pi, Q30
	function automatic longint cir_q30(input int i);
		longint tc;
		longint unsigned term;
		int d;
		tc = 64'sd0;
		if (i == 0)
			return longint'((QUARTER_PI60 + PI_Q30 / 2) / PI_Q30);
		for (int k = 0; k < 31; k++) begin
			d = 2 * k + 1;
			if (i * d <= 60) begin
				term = (64'd1 << (60 - i * d)) / 64'(d);
				if (k % 2 == 1)
					tc = tc - longint'(term);
				else
					tc = tc + longint'(term);
			end
		end
		return longint'((longint'(unsigned'(tc)) + PI_Q30 / 2) / PI_Q30);
	endfunction

endpackage

// ----- src/map_tile_to_bounding_box.sv -----
// ----------------------------------------------------------------------------
// map_tile_to_bounding_box
// Bounding box of one slippy-map tile, in degrees or Web Mercator metres,
// signed fixed point with FRAC_BITS fraction bits.
//
//   channel  direction  handshake                 payload
//   tile     in         tile_valid / tile_stall   tile_x, tile_y, zoom
//   bbox     out        bbox_valid / bbox_stall   valid_res, min/max x/y
//   config   in         wr_en                     wr_index, wr_data
//
// One tile per cycle unless bbox stalls; depth is set by the two latitude
// CORDIC lanes (32 hyperbolic + 31 circular stages) and the output register.
// The whole pipeline advances together; a stalled result freezes it and
// tile_stall rises only while bbox holds a result that is not taken.
// Reset clears the valid line and loads the config defaults; no clearing pass.
// ----------------------------------------------------------------------------
module map_tile_to_bounding_box #(
	parameter int MAX_ZOOM  = mttb_pkg::MAX_ZOOM_DEF,
	parameter int FRAC_BITS = mttb_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic        [mttb_pkg::IDX_W-1:0]    wr_index,
	input  logic        [mttb_pkg::HW_W-1:0]     wr_data,
	input  logic                                 tile_valid,
	output logic                                 tile_stall,
	input  logic        [mttb_pkg::TILE_W-1:0]   tile_x,
	input  logic        [mttb_pkg::TILE_W-1:0]   tile_y,
	input  logic        [mttb_pkg::ZOOM_W-1:0]   zoom,
	output logic                                 bbox_valid,
	input  logic                                 bbox_stall,
	output logic                                 valid_res,
	output logic signed [mttb_pkg::COORD_W-1:0]  min_x,
	output logic signed [mttb_pkg::COORD_W-1:0]  min_y,
	output logic signed [mttb_pkg::COORD_W-1:0]  max_x,
	output logic signed [mttb_pkg::COORD_W-1:0]  max_y
);

	localparam int LAT  = mttb_pkg::LAT_DEPTH;
	localparam int SIDE = mttb_pkg::LAT_DEPTH - mttb_pkg::LIN_DEPTH;
	localparam int TW   = mttb_pkg::TILE_W;
	localparam int ZW   = mttb_pkg::ZOOM_W;
	localparam int NW   = mttb_pkg::NUM_W;
	localparam int CW   = mttb_pkg::COORD_W;

	logic [mttb_pkg::PROJ_W-1:0] projection_q;
	logic [mttb_pkg::HW_W-1:0]   half_world_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			projection_q <= mttb_pkg::PROJ_GEO;
			half_world_q <= mttb_pkg::HALF_WORLD_RST;
		end else if (wr_en) begin
			case (wr_index)
				mttb_pkg::REG_PROJECTION: projection_q <= wr_data[mttb_pkg::PROJ_W-1:0];
				mttb_pkg::REG_HALF_WORLD: half_world_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic bbox_valid_q;

	assign en         = !bbox_valid_q || !bbox_stall;
	assign tile_stall = !en;

	// range check at entry
	logic in_ok;
	assign in_ok = (32'(zoom) <= 32'(MAX_ZOOM)) && ((tile_x >> zoom) == '0)
		&& ((tile_y >> zoom) == '0);

	// side line: valid, range flag, tile fields
	logic          v_s  [1:LAT];
	logic          ok_s [1:LAT];
	logic [TW-1:0] tx_s [1:SIDE];
	logic [TW-1:0] ty_s [1:SIDE];
	logic [ZW-1:0] zm_s [1:SIDE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= tile_valid;
			for (int k = 2; k <= LAT; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s[1] <= in_ok;
			tx_s[1] <= tile_x;
			ty_s[1] <= tile_y;
			zm_s[1] <= zoom;
			for (int k = 2; k <= LAT; k++)
				ok_s[k] <= ok_s[k-1];
			for (int k = 2; k <= SIDE; k++) begin
				tx_s[k] <= tx_s[k-1];
				ty_s[k] <= ty_s[k-1];
				zm_s[k] <= zm_s[k-1];
			end
		end
	end

	// latitude lanes, fed at entry
	logic signed [CW-1:0] lat_n, lat_s;

	mttb_lat #(.FRAC_BITS(FRAC_BITS)) u_lat_n (
		.clk      (clk),
		.en       (en),
		.edge_idx ({1'b0, tile_y}),
		.zoom     (zoom),
		.coord    (lat_n)
	);

	mttb_lat #(.FRAC_BITS(FRAC_BITS)) u_lat_s (
		.clk      (clk),
		.en       (en),
		.edge_idx (mttb_pkg::EDGE_W'(tile_y) + 1'b1),
		.zoom     (zoom),
		.coord    (lat_s)
	);

	// linear lanes, fed from the side line
	logic signed [NW-1:0]                tile_n;
	logic signed [NW-1:0]                tx2, ty2;
	logic signed [NW-1:0]                num_w, num_e, num_n, num_s;
	logic signed [mttb_pkg::MUL_W-1:0]   mul_x, mul_y;

	assign tile_n = $signed(NW'(1) << zm_s[SIDE]);
	assign tx2    = $signed({{(NW-TW-1){1'b0}}, tx_s[SIDE], 1'b0});
	assign ty2    = $signed({{(NW-TW-1){1'b0}}, ty_s[SIDE], 1'b0});
	assign num_w  = tx2 - tile_n;
	assign num_e  = tx2 + NW'(2) - tile_n;
	assign num_n  = tile_n - ty2;
	assign num_s  = tile_n - ty2 - NW'(2);
	assign mul_y  = $signed({1'b0, half_world_q});
	assign mul_x  = (projection_q == mttb_pkg::PROJ_GEO) ? mttb_pkg::MUL_W'(180) : mul_y;

	logic signed [CW-1:0] lin_w, lin_e, lin_n, lin_s;

	mttb_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_w (
		.clk(clk), .en(en), .num(num_w), .mul(mul_x), .zoom(zm_s[SIDE]), .coord(lin_w)
	);
	mttb_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_e (
		.clk(clk), .en(en), .num(num_e), .mul(mul_x), .zoom(zm_s[SIDE]), .coord(lin_e)
	);
	mttb_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_n (
		.clk(clk), .en(en), .num(num_n), .mul(mul_y), .zoom(zm_s[SIDE]), .coord(lin_n)
	);
	mttb_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_s (
		.clk(clk), .en(en), .num(num_s), .mul(mul_y), .zoom(zm_s[SIDE]), .coord(lin_s)
	);

	// ordering and output register
	logic                 good;
	logic signed [CW-1:0] y1, y2;

	assign good = ok_s[LAT] && (projection_q == mttb_pkg::PROJ_GEO
		|| projection_q == mttb_pkg::PROJ_MERC);
	assign y1   = (projection_q == mttb_pkg::PROJ_GEO) ? lat_n : lin_n;
	assign y2   = (projection_q == mttb_pkg::PROJ_GEO) ? lat_s : lin_s;

	logic                 valid_res_q;
	logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bbox_valid_q <= 1'b0;
		else if (en)
			bbox_valid_q <= v_s[LAT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res_q <= good;
			if (good) begin
				min_x_q <= (lin_w < lin_e) ? lin_w : lin_e;
				max_x_q <= (lin_w < lin_e) ? lin_e : lin_w;
				min_y_q <= (y1 < y2) ? y1 : y2;
				max_y_q <= (y1 < y2) ? y2 : y1;
			end else begin
				min_x_q <= '0;
				max_x_q <= '0;
				min_y_q <= '0;
				max_y_q <= '0;
			end
		end
	end

	assign bbox_valid = bbox_valid_q;
	assign valid_res  = valid_res_q;
	assign min_x      = min_x_q;
	assign min_y      = min_y_q;
	assign max_x      = max_x_q;
	assign max_y      = max_y_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		bbox_valid && !valid_res |-> min_x == 0 && min_y == 0 && max_x == 0 && max_y == 0)
		else $error("rejected tile carries nonzero coordinates");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		bbox_valid && valid_res |-> min_x <= max_x && min_y <= max_y)
		else $error("bounding box edges out of order");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		bbox_valid && bbox_stall |=> bbox_valid && $stable(min_x) && $stable(max_y))
		else $error("stalled transfer changed");

endmodule

// ----- src/mttb_lin.sv -----
// ----------------------------------------------------------------------------
// mttb_lin
// Linear edge lane: num * m scaled by 2^(FRAC_BITS-zoom), saturated to 42 bits.
// ----------------------------------------------------------------------------
module mttb_lin #(
	parameter int FRAC_BITS = mttb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [mttb_pkg::NUM_W-1:0]     num,
	input  logic signed [mttb_pkg::MUL_W-1:0]     mul,
	input  logic        [mttb_pkg::ZOOM_W-1:0]    zoom,
	output logic signed [mttb_pkg::COORD_W-1:0]   coord
);

	localparam int PROD_W = mttb_pkg::NUM_W + mttb_pkg::MUL_W;
	localparam int SC_W   = 64;

	logic signed [PROD_W-1:0]             p_s1;
	logic        [mttb_pkg::ZOOM_W-1:0]   zoom_s1;
	logic signed [SC_W-1:0]               sc;
	logic signed [SC_W-1:0]               sc_s2;
	logic signed [mttb_pkg::COORD_W-1:0]  coord_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= num * mul;
			zoom_s1 <= zoom;
		end
	end

	always_comb begin
		if (zoom_s1 <= mttb_pkg::ZOOM_W'(FRAC_BITS))
			sc = SC_W'(p_s1) <<< (mttb_pkg::ZOOM_W'(FRAC_BITS) - zoom_s1);
		else
			sc = SC_W'(p_s1) >>> (zoom_s1 - mttb_pkg::ZOOM_W'(FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s2 <= sc;
			if (sc_s2 > SC_W'(mttb_pkg::OUT_HI))
				coord_s3 <= mttb_pkg::OUT_HI;
			else if (sc_s2 < SC_W'(mttb_pkg::OUT_LO))
				coord_s3 <= mttb_pkg::OUT_LO;
			else
				coord_s3 <= mttb_pkg::COORD_W'(sc_s2);
		end
	end

	assign coord = coord_s3;

endmodule

// ----- src/mttb_lat.sv -----
// ----------------------------------------------------------------------------
// mttb_lat
// Latitude lane: Gudermannian of pi*(1-2e/n) in degrees via pipelined
// hyperbolic CORDIC, split squaring, and circular CORDIC vectoring.
// ----------------------------------------------------------------------------
module mttb_lat #(
	parameter int FRAC_BITS = mttb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic        [mttb_pkg::EDGE_W-1:0]    edge_idx,
	input  logic        [mttb_pkg::ZOOM_W-1:0]    zoom,
	output logic signed [mttb_pkg::COORD_W-1:0]   coord
);

	localparam int HN   = mttb_pkg::HYP_STEPS;
	localparam int CN   = mttb_pkg::CIR_STEPS;
	localparam int H_W  = 34;
	localparam int Z_W  = 32;
	localparam int V_W  = 36;
	localparam int A_W  = 34;
	localparam int P_W  = 70;
	localparam int D_W  = 46;
	localparam int HALF = H_W / 2;

	// front
	logic        [32:0]  shifted;
	logic signed [34:0]  s_val;
	logic        [30:0]  mag_s1;
	logic                neg_s1;
	logic        [62:0]  cprod;
	logic signed [Z_W-1:0] c_s2;
	logic                neg_s2;

	assign shifted = 33'(edge_idx) << (5'd31 - zoom);
	assign s_val   = $signed(35'(64'd1 << 30)) - $signed({2'b00, shifted});

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= s_val[34];
			mag_s1 <= s_val[34] ? 31'(-s_val) : 31'(s_val);
			neg_s2 <= neg_s1;
			c_s2   <= $signed({1'b0, cprod[62:32]});
		end
	end

	assign cprod = 63'(mag_s1) * 63'(mttb_pkg::PI_Q30);

	// hyperbolic rotation
	logic signed [H_W-1:0] hx_s [0:HN-1];
	logic signed [H_W-1:0] hy_s [0:HN-1];
	logic signed [Z_W-1:0] hz_s [0:HN-1];
	logic                  hn_s [0:HN-1];

	for (genvar k = 0; k < HN; k++) begin : g_hyp
		localparam int SH = mttb_pkg::hyp_shift(k);
		localparam logic signed [Z_W-1:0] ANG = Z_W'(mttb_pkg::hyp_q30(SH));
		logic signed [H_W-1:0] xi, yi;
		logic signed [Z_W-1:0] zi;
		logic                  ni;
		if (k == 0) begin : g_first
			assign xi = H_W'(64'sd1 <<< 30);
			assign yi = '0;
			assign zi = c_s2;
			assign ni = neg_s2;
		end else begin : g_next
			assign xi = hx_s[k-1];
			assign yi = hy_s[k-1];
			assign zi = hz_s[k-1];
			assign ni = hn_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				hn_s[k] <= ni;
				if (zi >= 0) begin
					hx_s[k] <= xi + (yi >>> SH);
					hy_s[k] <= yi + (xi >>> SH);
					hz_s[k] <= zi - ANG;
				end else begin
					hx_s[k] <= xi - (yi >>> SH);
					hy_s[k] <= yi - (xi >>> SH);
					hz_s[k] <= zi + ANG;
				end
			end
		end
	end

	// squaring: 17-bit halves, partial products, sums, final shift
	logic signed [HALF-1:0] xh, yh;
	logic signed [HALF:0]   xl, yl;
	logic signed [H_W:0]    xx_hh_s1, xx_hl_s1, xx_ll_s1;
	logic signed [H_W:0]    yy_hh_s1, yy_hl_s1, yy_ll_s1;
	logic signed [H_W:0]    xy_hh_s1, xy_hl_s1, xy_lh_s1, xy_ll_s1;
	logic                   mn_s1, mn_s2, mn_s3;
	logic signed [P_W-1:0]  pcc_s2, pss_s2, pcs_s2;
	logic signed [V_W-1:0]  vx_s3, vy_s3;
	logic signed [P_W-1:0]  psum;
	logic signed [P_W-1:0]  pdbl;

	assign xh = hx_s[HN-1][H_W-1:HALF];
	assign yh = hy_s[HN-1][H_W-1:HALF];
	assign xl = $signed({1'b0, hx_s[HN-1][HALF-1:0]});
	assign yl = $signed({1'b0, hy_s[HN-1][HALF-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1    <= hn_s[HN-1];
			xx_hh_s1 <= xh * xh;
			xx_hl_s1 <= xh * xl;
			xx_ll_s1 <= xl * xl;
			yy_hh_s1 <= yh * yh;
			yy_hl_s1 <= yh * yl;
			yy_ll_s1 <= yl * yl;
			xy_hh_s1 <= xh * yh;
			xy_hl_s1 <= xh * yl;
			xy_lh_s1 <= xl * yh;
			xy_ll_s1 <= xl * yl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s2  <= mn_s1;
			pcc_s2 <= (P_W'(xx_hh_s1) <<< (2 * HALF)) + (P_W'(xx_hl_s1) <<< (HALF + 1))
				+ P_W'(xx_ll_s1);
			pss_s2 <= (P_W'(yy_hh_s1) <<< (2 * HALF)) + (P_W'(yy_hl_s1) <<< (HALF + 1))
				+ P_W'(yy_ll_s1);
			pcs_s2 <= (P_W'(xy_hh_s1) <<< (2 * HALF))
				+ ((P_W'(xy_hl_s1) + P_W'(xy_lh_s1)) <<< HALF) + P_W'(xy_ll_s1);
		end
	end

	assign psum = pcc_s2 + pss_s2;
	assign pdbl = pcs_s2 >>> 29;

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s3 <= mn_s2;
			vx_s3 <= V_W'(psum >>> 30);
			vy_s3 <= V_W'(pdbl);
		end
	end

	// circular vectoring
	logic signed [V_W-1:0] cx_s [0:CN-1];
	logic signed [V_W-1:0] cy_s [0:CN-1];
	logic signed [A_W-1:0] ca_s [0:CN-1];
	logic                  cn_s [0:CN-1];

	for (genvar k = 0; k < CN; k++) begin : g_cir
		localparam logic signed [A_W-1:0] ANG = A_W'(mttb_pkg::cir_q30(k));
		logic signed [V_W-1:0] xi, yi;
		logic signed [A_W-1:0] ai;
		logic                  ni;
		if (k == 0) begin : g_first
			assign xi = vx_s3;
			assign yi = vy_s3;
			assign ai = '0;
			assign ni = mn_s3;
		end else begin : g_next
			assign xi = cx_s[k-1];
			assign yi = cy_s[k-1];
			assign ai = ca_s[k-1];
			assign ni = cn_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cn_s[k] <= ni;
				if (yi >= 0) begin
					cx_s[k] <= xi + (yi >>> k);
					cy_s[k] <= yi - (xi >>> k);
					ca_s[k] <= ai + ANG;
				end else begin
					cx_s[k] <= xi - (yi >>> k);
					cy_s[k] <= yi + (xi >>> k);
					ca_s[k] <= ai - ANG;
				end
			end
		end
	end

	// half-turns times 360 (twice the angle, in degrees), round to FRAC_BITS, apply sign
	localparam logic signed [D_W-1:0] RND = D_W'(64'sd1 <<< (29 - FRAC_BITS));

	logic signed [D_W-1:0]               deg;
	logic signed [mttb_pkg::COORD_W-1:0] r_s1;
	logic                                rn_s1;
	logic signed [mttb_pkg::COORD_W-1:0] coord_s2;

	assign deg = D_W'(ca_s[CN-1]) * D_W'(360) + RND;

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s1    <= cn_s[CN-1];
			r_s1     <= mttb_pkg::COORD_W'(deg >>> (30 - FRAC_BITS));
			coord_s2 <= rn_s1 ? -r_s1 : r_s1;
		end
	end

	assign coord = coord_s2;

endmodule
